/* hdl/psbb_pkg.sv */
// shared types, constants and register codes of the sprite blitter
`timescale 1ns / 1ps
package psbb_pkg;

  // screen geometry and palette size
  localparam int ROW_PITCH       = 384;
  localparam int SCREEN_ROWS     = 216;
  localparam int VISIBLE_COLUMNS = 320;
  localparam int LEFT_OFFSET     = 32;
  localparam int PALETTE_DEPTH   = 256;
  localparam int PAL_AW          = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // field widths
  localparam int IDX_W   = 8;
  localparam int COLOR_W = 16;
  localparam int ADDR_W  = 17;
  localparam int POS_W   = 10;
  localparam int SIZE_W  = 11;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;

  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(1024);

  // queue between front and back, depth a power of two
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // rgb565 channel masks and blend scale
  localparam logic [COLOR_W-1:0] RB_MASK = 16'hF81F;
  localparam logic [COLOR_W-1:0] G_MASK  = 16'h07E0;
  localparam logic [5:0] WEIGHT_FULL = 6'd32;
  localparam int WEIGHT_SHIFT = 5;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // draw modes
  localparam logic [1:0] MODE_COPY   = 2'd0;
  localparam logic [1:0] MODE_BLEND  = 2'd1;
  localparam logic [1:0] MODE_SHADOW = 2'd2;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_DRAW_MODE     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_ORIGIN_X      = 3'd1;
  localparam logic [CIDX_W-1:0] REG_ORIGIN_Y      = 3'd2;
  localparam logic [CIDX_W-1:0] REG_SPRITE_WIDTH  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SPRITE_HEIGHT = 3'd4;
  localparam logic [CIDX_W-1:0] REG_KEY_COLOR     = 3'd5;
  localparam logic [CIDX_W-1:0] REG_BLEND_WEIGHT  = 3'd6;

  typedef struct packed {
    logic               operation;
    logic [IDX_W-1:0]   entry_index;
    logic [COLOR_W-1:0] entry_color;
    logic [COLOR_W-1:0] background;
  } in_beat_t;

  typedef struct packed {
    logic               write_valid;
    logic [ADDR_W-1:0]  write_address;
    logic [COLOR_W-1:0] write_color;
    logic               last_pixel;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]         draw_mode;
    logic [SIZE_W-1:0]  origin_x;
    logic [SIZE_W-1:0]  origin_y;
    logic [SIZE_W-1:0]  sprite_width;
    logic [SIZE_W-1:0]  sprite_height;
    logic [COLOR_W-1:0] key_color;
    logic [4:0]         blend_weight;
  } cfg_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [COLOR_W-1:0] sprite;
    logic [COLOR_W-1:0] background;
    logic               on_screen;
    logic [ADDR_W-1:0]  address;
    logic               last;
  } q_entry_t;

endpackage

/* hdl/psbb_ram.sv */
// generic single write, single read port ram with registered read
`timescale 1ns / 1ps
module psbb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/psbb_front.sv */
// front end: accepts beats, loads the palette, tracks position and clips
`timescale 1ns / 1ps
module psbb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  psbb_pkg::in_beat_t  in_data,
  output logic                in_stall,
  input  psbb_pkg::cfg_t      cfg,
  input  logic                q_full,
  output logic                q_push,
  output psbb_pkg::q_entry_t  q_entry
);

  logic accept, pix_acc, load_acc, idx_hit;
  logic [psbb_pkg::COLOR_W-1:0] pal_rdata;

  logic [psbb_pkg::SIZE_W-1:0] w_eff, h_eff;
  logic [psbb_pkg::POS_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic                        col_end, row_end;
  logic [psbb_pkg::SIZE_W:0]   sx, sy;
  logic                        on_x, on_y;

  // pixel stage waiting on the palette read
  logic                          s1_valid_r, s1_valid_nxt;
  logic                          s1_on_r, s1_hit_r, s1_last_r;
  logic [psbb_pkg::POS_W-1:0]    s1_x_r, s1_y_r;
  logic [psbb_pkg::COLOR_W-1:0]  s1_bg_r;
  logic [psbb_pkg::ADDR_W+4:0]   addr_full;

  assign in_stall = s1_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign pix_acc  = accept && (in_data.operation == psbb_pkg::OP_PIXEL);
  assign load_acc = accept && (in_data.operation == psbb_pkg::OP_LOAD);
  assign idx_hit  = {1'b0, in_data.entry_index} < (psbb_pkg::IDX_W+1)'(psbb_pkg::PALETTE_DEPTH);

  psbb_ram #(
    .WIDTH(psbb_pkg::COLOR_W),
    .DEPTH(psbb_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (load_acc && idx_hit),
    .waddr (in_data.entry_index[psbb_pkg::PAL_AW-1:0]),
    .wdata (in_data.entry_color),
    .re    (pix_acc),
    .raddr (in_data.entry_index[psbb_pkg::PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  // zero acts as one, anything past the limit as the limit
  always_comb begin
    if (cfg.sprite_width == '0) begin
      w_eff = psbb_pkg::SIZE_W'(1);
    end else if (cfg.sprite_width > psbb_pkg::MAX_SIZE) begin
      w_eff = psbb_pkg::MAX_SIZE;
    end else begin
      w_eff = cfg.sprite_width;
    end
    if (cfg.sprite_height == '0) begin
      h_eff = psbb_pkg::SIZE_W'(1);
    end else if (cfg.sprite_height > psbb_pkg::MAX_SIZE) begin
      h_eff = psbb_pkg::MAX_SIZE;
    end else begin
      h_eff = cfg.sprite_height;
    end
  end

  assign col_end = ({1'b0, col_r} + psbb_pkg::SIZE_W'(1)) >= w_eff;
  assign row_end = ({1'b0, row_r} + psbb_pkg::SIZE_W'(1)) >= h_eff;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (pix_acc) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + psbb_pkg::POS_W'(1);
      end else begin
        col_nxt = col_r + psbb_pkg::POS_W'(1);
      end
    end
  end

  // screen position, sign bit on top
  assign sx   = {cfg.origin_x[psbb_pkg::SIZE_W-1], cfg.origin_x} + {2'b00, col_r};
  assign sy   = {cfg.origin_y[psbb_pkg::SIZE_W-1], cfg.origin_y} + {2'b00, row_r};
  assign on_x = !sx[psbb_pkg::SIZE_W]
             && (sx[psbb_pkg::SIZE_W-1:0] < psbb_pkg::SIZE_W'(psbb_pkg::VISIBLE_COLUMNS));
  assign on_y = !sy[psbb_pkg::SIZE_W]
             && (sy[psbb_pkg::SIZE_W-1:0] < psbb_pkg::SIZE_W'(psbb_pkg::SCREEN_ROWS));

  assign q_push       = s1_valid_r && !q_full;
  assign s1_valid_nxt = pix_acc || (s1_valid_r && !q_push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_on_r   <= on_x && on_y;
      s1_hit_r  <= idx_hit;
      s1_last_r <= col_end && row_end;
      s1_x_r    <= sx[psbb_pkg::POS_W-1:0];
      s1_y_r    <= sy[psbb_pkg::POS_W-1:0];
      s1_bg_r   <= in_data.background;
    end
  end

  assign addr_full = (psbb_pkg::ADDR_W+5)'(s1_y_r) * (psbb_pkg::ADDR_W+5)'(psbb_pkg::ROW_PITCH)
                   + (psbb_pkg::ADDR_W+5)'(s1_x_r)
                   + (psbb_pkg::ADDR_W+5)'(psbb_pkg::LEFT_OFFSET);

  always_comb begin
    q_entry.sprite     = s1_hit_r ? pal_rdata : '0;
    q_entry.background = s1_bg_r;
    q_entry.on_screen  = s1_on_r;
    q_entry.address    = addr_full[psbb_pkg::ADDR_W-1:0];
    q_entry.last       = s1_last_r;
  end

endmodule

/* hdl/psbb_queue.sv */
// short fifo of classified pixels between front and back
`timescale 1ns / 1ps
module psbb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  psbb_pkg::q_entry_t push_entry,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output psbb_pkg::q_entry_t head
);

  psbb_pkg::q_entry_t           mem_r [psbb_pkg::Q_DEPTH];
  logic [psbb_pkg::Q_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [psbb_pkg::Q_CW-1:0]    count_r, count_nxt;

  assign full      = count_r == psbb_pkg::Q_CW'(psbb_pkg::Q_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + psbb_pkg::Q_CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - psbb_pkg::Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + psbb_pkg::Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + psbb_pkg::Q_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* hdl/psbb_back.sv */
// back end: key test, colour modes and the output register
`timescale 1ns / 1ps
module psbb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  psbb_pkg::cfg_t      cfg,
  input  logic                q_not_empty,
  input  psbb_pkg::q_entry_t  q_head,
  output logic                q_pop,
  output logic                out_valid,
  output psbb_pkg::out_beat_t out_data,
  input  logic                out_stall
);

  logic                          out_valid_r, out_valid_nxt;
  psbb_pkg::out_beat_t           out_data_r, out_data_nxt;
  logic                          draw;
  logic [psbb_pkg::COLOR_W-1:0]  blend_color, shadow_color;

  // one channel group of the weighted mix
  function automatic logic [psbb_pkg::COLOR_W-1:0] blend_part(
    input logic [psbb_pkg::COLOR_W-1:0] s,
    input logic [psbb_pkg::COLOR_W-1:0] b,
    input logic [psbb_pkg::COLOR_W-1:0] m,
    input logic [4:0]                   w
  );
    logic [21:0] sum;
    sum = 22'(s & m) * 22'(w) + 22'(b & m) * 22'(psbb_pkg::WEIGHT_FULL - {1'b0, w});
    return sum[psbb_pkg::WEIGHT_SHIFT +: psbb_pkg::COLOR_W] & m;
  endfunction

  assign blend_color  = blend_part(q_head.sprite, q_head.background, psbb_pkg::RB_MASK,
                                   cfg.blend_weight)
                      | blend_part(q_head.sprite, q_head.background, psbb_pkg::G_MASK,
                                   cfg.blend_weight);
  assign shadow_color = ((q_head.background & psbb_pkg::RB_MASK) >> 1) & psbb_pkg::RB_MASK
                      | ((q_head.background & psbb_pkg::G_MASK) >> 1) & psbb_pkg::G_MASK;

  assign draw  = q_head.on_screen && (q_head.sprite != cfg.key_color);
  assign q_pop = q_not_empty && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (q_pop) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.write_valid   = draw;
      out_data_nxt.last_pixel    = q_head.last;
      out_data_nxt.write_address = draw ? q_head.address : '0;
      out_data_nxt.write_color   = '0;
      if (draw) begin
        case (cfg.draw_mode)
          psbb_pkg::MODE_BLEND:  out_data_nxt.write_color = blend_color;
          psbb_pkg::MODE_SHADOW: out_data_nxt.write_color = shadow_color;
          default:               out_data_nxt.write_color = q_head.sprite;
        endcase
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/palette_sprite_blit_blend.sv */
// top level of the palette sprite blitter with key, blend and shadow modes
//
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+------------------------------------------
//  in_     | in        | in_valid/in_stall  | in_beat_t: load or pixel with background
//  out_    | out       | out_valid/out_stall| out_beat_t: one per pixel beat
//  cfg_    | in        | cfg_valid/cfg_ready| register index and data, always ready
//
//  one beat a cycle sustained while neither in_stall nor out_stall holds; a pixel beat reaches out_
//  through the palette read, a queue slot and the output register, loads give no result
//  the palette ram read port sets the front stage; everything else is one level deep
//  synchronous active-low reset clears counters, queue and config; palette is not cleared
//  an out_stall backs up the four-entry queue, and in_stall rises only once it is full
`timescale 1ns / 1ps
module palette_sprite_blit_blend (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  psbb_pkg::in_beat_t                in_data,
  output logic                              in_stall,
  output logic                              out_valid,
  output psbb_pkg::out_beat_t               out_data,
  input  logic                              out_stall,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [psbb_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [psbb_pkg::CDATA_W-1:0]      cfg_data
);

  psbb_pkg::cfg_t     cfg_r, cfg_nxt;
  logic               q_push, q_pop, q_full, q_not_empty;
  psbb_pkg::q_entry_t q_in, q_head;

  // register bank takes a write every cycle
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psbb_pkg::REG_DRAW_MODE:     cfg_nxt.draw_mode     = cfg_data[1:0];
        psbb_pkg::REG_ORIGIN_X:      cfg_nxt.origin_x      = cfg_data[psbb_pkg::SIZE_W-1:0];
        psbb_pkg::REG_ORIGIN_Y:      cfg_nxt.origin_y      = cfg_data[psbb_pkg::SIZE_W-1:0];
        psbb_pkg::REG_SPRITE_WIDTH:  cfg_nxt.sprite_width  = cfg_data[psbb_pkg::SIZE_W-1:0];
        psbb_pkg::REG_SPRITE_HEIGHT: cfg_nxt.sprite_height = cfg_data[psbb_pkg::SIZE_W-1:0];
        psbb_pkg::REG_KEY_COLOR:     cfg_nxt.key_color     = cfg_data[psbb_pkg::COLOR_W-1:0];
        psbb_pkg::REG_BLEND_WEIGHT:  cfg_nxt.blend_weight  = cfg_data[4:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.draw_mode     <= psbb_pkg::MODE_COPY;
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.sprite_width  <= psbb_pkg::SIZE_W'(1);
      cfg_r.sprite_height <= psbb_pkg::SIZE_W'(1);
      cfg_r.key_color     <= '0;
      cfg_r.blend_weight  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: palette loads, position tracking and clipping
  psbb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  // decouples the pixel stream from output back-pressure
  psbb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // back: key compare, colour mode and result register
  psbb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall)
  );

endmodule

/* hdl/psbb_checker.sv */
// port-level checker for the sprite blitter and its bind
`timescale 1ns / 1ps
module psbb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input psbb_pkg::out_beat_t out_data,
  input logic                out_stall
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_suppressed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.write_valid |->
      out_data.write_address == '0 && out_data.write_color == '0)
    else $error("suppressed pixel carries address or colour");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output back-pressure");

endmodule

bind palette_sprite_blit_blend psbb_checker u_psbb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_data  (out_data),
  .out_stall (out_stall)
);

/* tb/sv/blit_checker.sv */
// checker for the sprite blitter: predicts frame buffer writes and compares them
`timescale 1ns / 1ps
module blit_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  psbb_pkg::in_beat_t           in_data,
  input  logic                         in_stall,
  input  logic                         out_valid,
  input  psbb_pkg::out_beat_t          out_data,
  input  logic                         out_stall,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [psbb_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [psbb_pkg::CDATA_W-1:0] cfg_data,
  output int                           mismatch_count,
  output int                           writes_pending
);
  import psbb_pkg::*;

  cfg_t               regs;
  logic [COLOR_W-1:0] palette [PALETTE_DEPTH];
  logic [POS_W-1:0]   col_pos;
  logic [POS_W-1:0]   row_pos;
  out_beat_t          expected_writes [$];
  int                 fail_total;

  // size registers: zero acts as one, anything past the maximum as the maximum
  function automatic int clamp_size(logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIZE) return int'(MAX_SIZE);
    return int'(v);
  endfunction

  function automatic logic [COLOR_W-1:0] mix_channel(logic [COLOR_W-1:0] s,
                                                     logic [COLOR_W-1:0] b,
                                                     logic [COLOR_W-1:0] m,
                                                     logic [4:0] w);
    logic [31:0] acc;
    acc = 32'(s & m) * 32'(w) + 32'(b & m) * (32'(WEIGHT_FULL) - 32'(w));
    return COLOR_W'(acc >> WEIGHT_SHIFT) & m;
  endfunction

  function automatic out_beat_t predict_write(in_beat_t b);
    int                 sx;
    int                 sy;
    logic [COLOR_W-1:0] spr;
    out_beat_t          w;
    w   = '0;
    spr = (int'(b.entry_index) < PALETTE_DEPTH) ? palette[b.entry_index] : '0;
    sx  = int'($signed(regs.origin_x)) + int'(col_pos);
    sy  = int'($signed(regs.origin_y)) + int'(row_pos);
    if (sx >= 0 && sx < VISIBLE_COLUMNS && sy >= 0 && sy < SCREEN_ROWS &&
        spr != regs.key_color) begin
      w.write_valid   = 1'b1;
      w.write_address = ADDR_W'(sy * ROW_PITCH + sx + LEFT_OFFSET);
      case (regs.draw_mode)
        MODE_BLEND: begin
          w.write_color = mix_channel(spr, b.background, RB_MASK, regs.blend_weight) |
                          mix_channel(spr, b.background, G_MASK, regs.blend_weight);
        end
        MODE_SHADOW: begin
          w.write_color = (((b.background & RB_MASK) >> 1) & RB_MASK) |
                          (((b.background & G_MASK) >> 1) & G_MASK);
        end
        default: begin
          w.write_color = spr;
        end
      endcase
    end
    w.last_pixel = (int'(col_pos) + 1 >= clamp_size(regs.sprite_width)) &&
                   (int'(row_pos) + 1 >= clamp_size(regs.sprite_height));
    return w;
  endfunction

  always @(posedge clk) begin : monitor
    out_beat_t oldest;
    if (!rst_n) begin
      regs               = '0;
      regs.sprite_width  = SIZE_W'(1);
      regs.sprite_height = SIZE_W'(1);
      col_pos            = '0;
      row_pos            = '0;
      fail_total         = 0;
      expected_writes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DRAW_MODE:     regs.draw_mode     = cfg_data[1:0];
          REG_ORIGIN_X:      regs.origin_x      = cfg_data[SIZE_W-1:0];
          REG_ORIGIN_Y:      regs.origin_y      = cfg_data[SIZE_W-1:0];
          REG_SPRITE_WIDTH:  regs.sprite_width  = cfg_data[SIZE_W-1:0];
          REG_SPRITE_HEIGHT: regs.sprite_height = cfg_data[SIZE_W-1:0];
          REG_KEY_COLOR:     regs.key_color     = cfg_data[COLOR_W-1:0];
          REG_BLEND_WEIGHT:  regs.blend_weight  = cfg_data[4:0];
          default: ;
        endcase
      end
      // a result always leaves after its pixel is accepted, so match before predicting
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          $error("unexpected write beat %h", out_data);
          fail_total++;
        end else begin
          oldest = expected_writes.pop_front();
          if (out_data.write_valid !== oldest.write_valid) begin
            $error("write_valid: expected %0d, got %0d", oldest.write_valid,
                   out_data.write_valid);
            fail_total++;
          end
          if (out_data.write_address !== oldest.write_address) begin
            $error("write_address: expected %0d, got %0d", oldest.write_address,
                   out_data.write_address);
            fail_total++;
          end
          if (out_data.write_color !== oldest.write_color) begin
            $error("write_color: expected %h, got %h", oldest.write_color,
                   out_data.write_color);
            fail_total++;
          end
          if (out_data.last_pixel !== oldest.last_pixel) begin
            $error("last_pixel: expected %0d, got %0d", oldest.last_pixel,
                   out_data.last_pixel);
            fail_total++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.operation == OP_LOAD) begin
          if (int'(in_data.entry_index) < PALETTE_DEPTH)
            palette[in_data.entry_index] = in_data.entry_color;
        end else begin
          expected_writes.push_back(predict_write(in_data));
          if (int'(col_pos) + 1 >= clamp_size(regs.sprite_width)) begin
            col_pos = '0;
            if (int'(row_pos) + 1 >= clamp_size(regs.sprite_height)) row_pos = '0;
            else row_pos = row_pos + 1'b1;
          end else begin
            col_pos = col_pos + 1'b1;
          end
        end
      end
    end
    mismatch_count <= fail_total;
    writes_pending <= expected_writes.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// testbench top for the sprite blitter: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module tb_top;
  import psbb_pkg::*;

  // codes outside the documented ranges, still legal on the wires
  localparam logic [1:0]        MODE_SPARE = 2'd3;
  localparam logic [CIDX_W-1:0] REG_SPARE  = 3'd7;

  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES  = 48;  // long receiver hold-off, fills the queue
  localparam int TAIL_CYCLES  = 12;  // idle tail after the drain, lets the pipeline empty

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  in_beat_t           in_data;
  logic               in_stall;
  logic               out_valid;
  out_beat_t          out_data;
  logic               out_stall;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CDATA_W-1:0] cfg_data;

  int mismatch_count;
  int writes_pending;

  // idle percentages of each side, changed only while the block is quiet
  int send_idle = 0;
  int recv_idle = 0;
  // each bump asks the receiver for one long hold-off
  int hold_tag  = 0;
  int items_sent;

  // palette slots loaded so far, so that no pixel reads an unwritten slot
  bit                 slot_loaded [256];
  logic [COLOR_W-1:0] slot_colour [256];
  int                 loaded_slots [$];

  palette_sprite_blit_blend i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  blit_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_data        (in_data),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .out_stall      (out_stall),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .writes_pending (writes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #6_000_000;
    $display("palette_sprite_blit_blend regression: fail");
    $finish;
  end

  // receiver: random stall per cycle, or a long hold-off when asked
  initial begin : receiver
    int hold_seen;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_tag) begin
        hold_seen = hold_tag;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  function automatic int fit_size(int v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return v;
  endfunction

  function automatic int pick_slot();
    return loaded_slots[$urandom_range(loaded_slots.size() - 1)];
  endfunction

  // offer one beat and return at the edge that takes it; valid stays high
  task automatic send_beat(in_beat_t b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_slot(int idx, logic [COLOR_W-1:0] colour);
    in_beat_t beat;
    beat             = '0;
    beat.operation   = OP_LOAD;
    beat.entry_index = IDX_W'(idx);
    beat.entry_color = colour;
    beat.background  = COLOR_W'($urandom);  // unused on a load, toggled anyway
    send_beat(beat);
    if (!slot_loaded[idx]) begin
      slot_loaded[idx] = 1'b1;
      loaded_slots.push_back(idx);
    end
    slot_colour[idx] = colour;
  endtask

  task automatic draw_pixel(int idx, logic [COLOR_W-1:0] bg);
    in_beat_t beat;
    beat             = '0;
    beat.operation   = OP_PIXEL;
    beat.entry_index = IDX_W'(idx);
    beat.entry_color = COLOR_W'($urandom);  // ignored on a pixel
    beat.background  = bg;
    send_beat(beat);
  endtask

  // stop offering and wait until every predicted write has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
  endtask

  // loads give no result, so allow the pipeline to empty behind the last write
  task automatic quiesce();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // one register write, back to back with the next; program_regs drops valid after the last one
  task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(logic [1:0] mode, int ox, int oy, int wd, int ht,
                              logic [COLOR_W-1:0] key_colour, logic [4:0] weight,
                              bit touch_spare);
    cfg_write(REG_DRAW_MODE,     CDATA_W'(mode));
    cfg_write(REG_ORIGIN_X,      CDATA_W'(ox));
    cfg_write(REG_ORIGIN_Y,      CDATA_W'(oy));
    cfg_write(REG_SPRITE_WIDTH,  CDATA_W'(wd));
    cfg_write(REG_SPRITE_HEIGHT, CDATA_W'(ht));
    cfg_write(REG_KEY_COLOR,     key_colour);
    cfg_write(REG_BLEND_WEIGHT,  CDATA_W'(weight));
    if (touch_spare) cfg_write(REG_SPARE, '1);
    cfg_valid <= 1'b0;
  endtask

  // one random sprite: settings, a few palette loads, then its pixels
  task automatic random_phase(int phase_no);
    logic [1:0]         mode;
    int                 ox;
    int                 oy;
    int                 wd;
    int                 ht;
    int                 npix;
    logic [COLOR_W-1:0] key_colour;
    logic [4:0]         weight;
    quiesce();
    // idling regimes: sender light and receiver heavy, then swapped, then none
    if (items_sent < RANDOM_ITEMS / 3) begin
      send_idle = 26;
      recv_idle = 57;
    end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
      send_idle = 57;
      recv_idle = 26;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if ($urandom_range(9) == 0) mode = MODE_SPARE;
    else mode = 2'($urandom_range(2));
    // origins mostly straddle the screen edges so clipping is busy
    case ($urandom_range(9))
      0:       ox = -1024;
      1:       ox = 1023;
      2:       ox = int'($urandom_range(2047)) - 1024;
      default: ox = int'($urandom_range(360)) - 24;
    endcase
    case ($urandom_range(9))
      0:       oy = -1024;
      1:       oy = 1023;
      2:       oy = int'($urandom_range(2047)) - 1024;
      default: oy = int'($urandom_range(250)) - 16;
    endcase
    // small sprites mostly, a few degenerate or oversized ones
    case ($urandom_range(19))
      0:       wd = 0;
      1:       wd = 1024;
      2:       wd = 2047;
      3:       wd = 1025 + int'($urandom_range(1021));
      default: wd = 1 + int'($urandom_range(15));
    endcase
    case ($urandom_range(19))
      0:       ht = 0;
      1:       ht = 1024;
      2:       ht = 2047;
      default: ht = 1 + int'($urandom_range(7));
    endcase
    if ($urandom_range(1)) key_colour = slot_colour[pick_slot()];
    else key_colour = COLOR_W'($urandom);
    weight = 5'($urandom_range(31));
    program_regs(mode, ox, oy, wd, ht, key_colour, weight, 1'b0);

    npix = fit_size(wd) * fit_size(ht);
    if (npix > 64) npix = 20 + int'($urandom_range(40));
    // now and then a sprite cut short or run one pixel over, so the counters carry into the next one
    if ($urandom_range(4) == 0) npix = 1 + int'($urandom_range(npix));
    repeat ($urandom_range(4)) load_slot($urandom_range(255), COLOR_W'($urandom));
    if (phase_no % 7 == 3) hold_tag <= hold_tag + 1;
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(99) < 12) load_slot($urandom_range(255), COLOR_W'($urandom));
      draw_pixel(pick_slot(), COLOR_W'($urandom));
      // sender pause until all writes are back, mid-sprite
      if (phase_no % 5 == 2 && i == npix / 2) drain();
    end
  endtask

  initial begin : stimulus
    int phase_no;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // opaque copy at the origin, key colour zero
    program_regs(MODE_COPY, 0, 0, 1, 1, 16'h0000, 5'd0, 1'b1);
    load_slot(0,   16'h0000);
    load_slot(255, 16'hFFFF);
    load_slot(1,   16'h8421);
    load_slot(2,   16'h7BEF);
    draw_pixel(255, 16'h0000);
    draw_pixel(0,   16'hFFFF);  // key colour, suppressed

    // maximum-weight blend on the bottom-right corner, three quarters clipped
    quiesce();
    program_regs(MODE_BLEND, 319, 215, 2, 2, 16'hFFFF, 5'd31, 1'b0);
    draw_pixel(1,   16'hFFFF);
    draw_pixel(2,   16'h0000);
    draw_pixel(1,   16'hAAAA);
    draw_pixel(255, 16'h0000);

    // zero-weight blend gives the background back
    quiesce();
    program_regs(MODE_BLEND, 100, 50, 1, 1, 16'h0001, 5'd0, 1'b0);
    draw_pixel(2, 16'hFFFF);

    // shadow; zero width acts as one and an oversized height as the maximum
    quiesce();
    program_regs(MODE_SHADOW, 0, 0, 0, 2047, 16'h0000, 5'd16, 1'b0);
    draw_pixel(1, 16'hFFFF);
    draw_pixel(2, 16'h5555);

    // unused mode off screen, leaving the column part way along
    quiesce();
    program_regs(MODE_SPARE, 1023, 1023, 8, 1, 16'h1234, 5'd31, 1'b0);
    draw_pixel(255, 16'h0000);
    draw_pixel(1,   16'hFFFF);
    draw_pixel(2,   16'h0F0F);

    // shrink the sprite under the column counter, which then counts as the last
    quiesce();
    program_regs(MODE_SPARE, 5, 7, 2, 1, 16'h0001, 5'd8, 1'b0);
    draw_pixel(255, 16'h0F0F);
    draw_pixel(1,   16'hF0F0);
    draw_pixel(2,   16'h1234);

    items_sent = 0;
    phase_no   = 0;
    while (items_sent < RANDOM_ITEMS) begin
      random_phase(phase_no);
      phase_no++;
    end

    quiesce();
    if (mismatch_count == 0) begin
      $display("palette_sprite_blit_blend regression: pass");
    end else begin
      $display("palette_sprite_blit_blend regression: fail");
    end
    $finish;
  end

endmodule

/* palette_sprite_blit_blend.f */
hdl/psbb_pkg.sv
hdl/psbb_ram.sv
hdl/psbb_front.sv
hdl/psbb_queue.sv
hdl/psbb_back.sv
hdl/palette_sprite_blit_blend.sv
hdl/psbb_checker.sv
tb/sv/blit_checker.sv
tb/sv/tb_top.sv
